[rtl/ospt_pkg.sv]
`default_nettype none

package ospt_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TICK_BITS  = 32;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MASK_W     = 8;

  typedef enum logic [2:0] {
    ACT_INIT    = 3'd0,
    ACT_START   = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_DESTROY = 3'd3,
    ACT_TICK    = 3'd4,
    ACT_QUERY   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_CREATED   = 2'd0,
    ST_STARTED   = 2'd1,
    ST_STOPPED   = 2'd2,
    ST_DESTROYED = 2'd3
  } tstate_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_OP   = 1'b1
  } fsm_t;

  typedef struct packed {
    action_t     action;
    logic [2:0]  timer_id;
    logic [31:0] start_delay;
    logic [31:0] period;
    logic        hard_type;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] expired_hard_mask;
    logic [MASK_W-1:0] expired_soft_mask;
    logic [31:0]       info_start_delay;
    logic [31:0]       info_period;
    logic              info_hard;
    tstate_t           info_state;
  } out_item_t;

  // One row of the timer table.
  typedef struct packed {
    logic [31:0]          delay;
    logic [31:0]          period;
    logic [TICK_BITS-1:0] count;
    tstate_t              state;
    logic                 active;
    logic                 hard;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    delay:  32'd0,
    period: 32'd0,
    count:  {TICK_BITS{1'b0}},
    state:  ST_DESTROYED,
    active: 1'b0,
    hard:   1'b0
  };

endpackage

`default_nettype wire

[rtl/ospt_table.sv]
`default_nettype none

module ospt_table (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [ospt_pkg::IDX_W-1:0] rd_addr,
  output ospt_pkg::entry_t           rd_data,
  input  wire logic                  wr_en,
  input  wire logic [ospt_pkg::IDX_W-1:0] wr_addr,
  input  wire ospt_pkg::entry_t      wr_data
);
  import ospt_pkg::*;

  entry_t                mem_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld_r;
  entry_t                rd_q_r;
  logic                  rd_vld_r;

  // Mark rows written since reset; unwritten rows read as the reset row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r   <= mem_r[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  assign rd_data = rd_vld_r ? rd_q_r : ENTRY_RESET;

endmodule

`default_nettype wire

[rtl/one_shot_periodic_timer_bank.sv]
`default_nettype none

// Channel   | Ports                       | Handshake
// ----------+-----------------------------+---------------------------------------
// command   | start, busy, in_item        | beat taken at edge with start && !busy
// result    | out_valid, out_result       | beat shown one cycle, no back-pressure
//
// Steps: a tick accepts the command, then handles one table row per cycle through
// the single read port; every other action accepts, then handles its one row.
// The result beat appears in the cycle after the last row is handled; busy is
// already low then, so the next command may be taken in that same cycle.
// Reset: synchronous, active low; all timers read as destroyed until written.
// Stalls: none on the result side; the receiver must take every beat.

module one_shot_periodic_timer_bank (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire ospt_pkg::in_item_t in_item,
  output logic                 out_valid,
  output ospt_pkg::out_item_t  out_result
);
  import ospt_pkg::*;

  fsm_t                  state_r, state_nxt;
  in_item_t              cmd_r;
  logic [IDX_W-1:0]      idx_r;
  logic [MASK_W-1:0]     hmask_r, hmask_nxt;
  logic [MASK_W-1:0]     smask_r, smask_nxt;
  logic                  out_valid_r;
  out_item_t             out_result_r;

  logic                  accept;
  logic                  finish;
  logic                  last;
  logic                  id_ok;
  logic                  fire;
  logic [IDX_W-1:0]      rd_addr;
  entry_t                rd_data;
  logic                  wr_en;
  entry_t                wr_data;
  out_item_t             res;

  // Count to load: the start delay, or the period when the delay is zero.
  function automatic logic [TICK_BITS-1:0] initial_count(input logic [31:0] d,
                                                        input logic [31:0] p);
    return (d != 32'd0) ? d[TICK_BITS-1:0] : p[TICK_BITS-1:0];
  endfunction

  ospt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_data)
  );

  assign accept = start && (state_r == S_IDLE);
  assign last   = (int'(idx_r) == NUM_TIMERS - 1);
  assign id_ok  = (int'(cmd_r.timer_id) < NUM_TIMERS);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_OP;
      end
      S_OP: begin
        if (finish) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs: read a row, modify it and write it back, or report it for a query.
  always_comb begin
    busy      = (state_r != S_IDLE);
    wr_en     = 1'b0;
    wr_data   = rd_data;
    hmask_nxt = hmask_r;
    smask_nxt = smask_r;
    res       = '0;
    finish    = 1'b0;
    fire      = 1'b0;

    // In idle, fetch the addressed row (row 0 for a tick walk); while walking,
    // prefetch the next row. The row written this cycle is never the one read.
    if (state_r == S_IDLE) begin
      rd_addr = (in_item.action == ACT_TICK) ? '0 : IDX_W'(in_item.timer_id);
    end else begin
      rd_addr = idx_r + 1'b1;
    end

    if (state_r == S_OP) begin
      unique case (cmd_r.action)
        ACT_TICK: begin
          wr_en  = 1'b1;
          finish = last;
          if (rd_data.active) begin
            if (rd_data.count == '0) begin
              fire = 1'b1;
            end else begin
              wr_data.count = rd_data.count - 1'b1;
              fire          = (rd_data.count == TICK_BITS'(1));
            end
          end
          if (fire) begin
            for (int k = 0; k < MASK_W; k++) begin
              if (int'(idx_r) == k) begin
                if (rd_data.hard) hmask_nxt[k] = 1'b1;
                else              smask_nxt[k] = 1'b1;
              end
            end
            // Reload a periodic timer; drop a one-shot to stopped.
            if (rd_data.period != 32'd0) begin
              wr_data.count = rd_data.period[TICK_BITS-1:0];
            end else begin
              wr_data.active = 1'b0;
              wr_data.state  = ST_STOPPED;
            end
          end
          res.expired_hard_mask = hmask_nxt;
          res.expired_soft_mask = smask_nxt;
        end
        ACT_INIT: begin
          finish         = 1'b1;
          wr_en          = id_ok;
          wr_data.delay  = cmd_r.start_delay;
          wr_data.period = cmd_r.period;
          wr_data.count  = initial_count(cmd_r.start_delay, cmd_r.period);
          wr_data.state  = ST_CREATED;
          wr_data.active = 1'b0;
          wr_data.hard   = cmd_r.hard_type;
        end
        ACT_START: begin
          finish = 1'b1;
          if (id_ok && (rd_data.state == ST_CREATED || rd_data.state == ST_STOPPED)) begin
            wr_en          = 1'b1;
            wr_data.count  = initial_count(rd_data.delay, rd_data.period);
            wr_data.state  = ST_STARTED;
            wr_data.active = 1'b1;
          end
        end
        ACT_STOP: begin
          finish = 1'b1;
          if (id_ok && rd_data.state == ST_STARTED) begin
            wr_en          = 1'b1;
            wr_data.active = 1'b0;
            wr_data.state  = ST_STOPPED;
          end
        end
        ACT_DESTROY: begin
          finish = 1'b1;
          if (id_ok) begin
            wr_en = 1'b1;
            if (rd_data.state == ST_STARTED) wr_data.active = 1'b0;
            wr_data.state = ST_DESTROYED;
          end
        end
        ACT_QUERY: begin
          finish = 1'b1;
          if (id_ok) begin
            res.info_start_delay = rd_data.delay;
            res.info_period      = rd_data.period;
            res.info_hard        = rd_data.hard;
            res.info_state       = rd_data.state;
          end else begin
            res.info_state = ST_DESTROYED;
          end
        end
        default: finish = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_OP) && finish;
    end
  end

  // Hold the command, advance the walk index, collect expiry bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_item;
      idx_r   <= (in_item.action == ACT_TICK) ? '0 : IDX_W'(in_item.timer_id);
      hmask_r <= '0;
      smask_r <= '0;
    end else if (state_r == S_OP) begin
      idx_r   <= idx_r + 1'b1;
      hmask_r <= hmask_nxt;
      smask_r <= smask_nxt;
      if (finish) out_result_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("command taken but block not busy");

  a_beat_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_OP) && !busy)
    else $error("result beat without a finished operation");

  a_walk_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OP && cmd_r.action == ACT_TICK && !last)
      |=> (state_r == S_OP) && (idx_r == $past(idx_r) + 1'b1))
    else $error("tick walk skipped or stopped early");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && cmd_r.action == ACT_TICK && !last) |-> (rd_addr != idx_r))
    else $error("row read while being written");

  a_single_op_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OP && cmd_r.action != ACT_TICK) |=> (state_r == S_IDLE))
    else $error("single-row action did not finish in one step");

endmodule

`default_nettype wire

[tb/one_shot_periodic_timer_bank_test.sv]
module one_shot_periodic_timer_bank_test;
  import ospt_pkg::*;

  // Tracks the timer table the block should hold and the result beats it
  // owes us, oldest first.
  class timer_scoreboard;
    logic [31:0]          delay_tab  [NUM_TIMERS];
    logic [31:0]          period_tab [NUM_TIMERS];
    logic [TICK_BITS-1:0] count_tab  [NUM_TIMERS];
    tstate_t              state_tab  [NUM_TIMERS];
    logic                 active_tab [NUM_TIMERS];
    logic                 hard_tab   [NUM_TIMERS];
    out_item_t            owed_q [$];
    int                   failures;

    function new();
      failures = 0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        delay_tab[i]  = '0;
        period_tab[i] = '0;
        count_tab[i]  = '0;
        state_tab[i]  = ST_DESTROYED;
        active_tab[i] = 1'b0;
        hard_tab[i]   = 1'b0;
      end
    endfunction

    // Load value: the start delay, or the period when the delay is zero.
    function logic [TICK_BITS-1:0] first_count(int i);
      return (delay_tab[i] != 32'd0) ? delay_tab[i][TICK_BITS-1:0]
                                     : period_tab[i][TICK_BITS-1:0];
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advance the table by one accepted command beat and queue its result.
    function void note_command(in_item_t c);
      out_item_t res;
      int        id;
      logic      fire;
      res = '0;
      id  = int'(c.timer_id);
      case (c.action)
        ACT_INIT: begin
          if (id < NUM_TIMERS) begin
            delay_tab[id]  = c.start_delay;
            period_tab[id] = c.period;
            hard_tab[id]   = c.hard_type;
            count_tab[id]  = first_count(id);
            state_tab[id]  = ST_CREATED;
            active_tab[id] = 1'b0;
          end
        end
        ACT_START: begin
          if (id < NUM_TIMERS &&
              (state_tab[id] == ST_CREATED || state_tab[id] == ST_STOPPED)) begin
            count_tab[id]  = first_count(id);
            state_tab[id]  = ST_STARTED;
            active_tab[id] = 1'b1;
          end
        end
        ACT_STOP, ACT_DESTROY: begin
          if (id < NUM_TIMERS) begin
            if (state_tab[id] == ST_STARTED) begin
              active_tab[id] = 1'b0;
              state_tab[id]  = ST_STOPPED;
            end
            if (c.action == ACT_DESTROY) state_tab[id] = ST_DESTROYED;
          end
        end
        ACT_TICK: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (active_tab[i]) begin
              if (count_tab[i] == '0) begin
                fire = 1'b1;
              end else begin
                count_tab[i] = count_tab[i] - 1'b1;
                fire = (count_tab[i] == '0);
              end
              if (fire) begin
                if (i < MASK_W) begin
                  if (hard_tab[i]) res.expired_hard_mask[i] = 1'b1;
                  else res.expired_soft_mask[i] = 1'b1;
                end
                if (period_tab[i] != 32'd0) begin
                  count_tab[i] = period_tab[i][TICK_BITS-1:0];
                end else begin
                  active_tab[i] = 1'b0;
                  state_tab[i]  = ST_STOPPED;
                end
              end
            end
          end
        end
        ACT_QUERY: begin
          if (id < NUM_TIMERS) begin
            res.info_start_delay = delay_tab[id];
            res.info_period      = period_tab[id];
            res.info_hard        = hard_tab[id];
            res.info_state       = state_tab[id];
          end else begin
            res.info_state = ST_DESTROYED;
          end
        end
        default: ;
      endcase
      owed_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result beat with nothing owed: hard=%h soft=%h dly=%h per=%h hd=%b st=%0d",
                   got.expired_hard_mask, got.expired_soft_mask, got.info_start_delay,
                   got.info_period, got.info_hard, got.info_state);
        return;
      end
      want = owed_q.pop_front();
      if (got.expired_hard_mask !== want.expired_hard_mask ||
          got.expired_soft_mask !== want.expired_soft_mask ||
          got.info_start_delay  !== want.info_start_delay  ||
          got.info_period       !== want.info_period       ||
          got.info_hard         !== want.info_hard         ||
          got.info_state        !== want.info_state) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch exp: hard=%h soft=%h dly=%h per=%h hd=%b st=%0d",
                   want.expired_hard_mask, want.expired_soft_mask, want.info_start_delay,
                   want.info_period, want.info_hard, want.info_state);
          $display("         got: hard=%h soft=%h dly=%h per=%h hd=%b st=%0d",
                   got.expired_hard_mask, got.expired_soft_mask, got.info_start_delay,
                   got.info_period, got.info_hard, got.info_state);
        end
      end
    endfunction
  endclass

  localparam int ITEM_COUNT = 2000;
  // No sender gaps once this many beats have gone in.
  localparam int QUIET_FROM = 1700;
  // Undefined action codes, outside the package enum.
  localparam logic [2:0] ACT_UNDEF_A = 3'd6;
  localparam logic [2:0] ACT_UNDEF_B = 3'd7;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_result;

  timer_scoreboard board = new();
  int issued = 0;

  one_shot_periodic_timer_bank uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a beat.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Watch both channels at every edge. Values read here are the ones that
  // stood before the edge, so order within the step does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check_result(out_result);
      if (start && !busy) board.note_command(in_item);
    end
  end

  // Drop start for a gap whose length is given by n.
  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Present one command beat and hold it until the block takes it. A random
  // gap may go in front, except near the end of the run.
  task automatic issue(input logic [2:0] code, input logic [2:0] id,
                       input logic [31:0] dly, input logic [31:0] per,
                       input logic hard);
    in_item_t c;
    if (issued < QUIET_FROM && $urandom_range(0, 5) == 0)
      pause($urandom_range(1, 19));
    c.action      = action_t'(code);
    c.timer_id    = id;
    c.start_delay = dly;
    c.period      = per;
    c.hard_type   = hard;
    start   <= 1'b1;
    in_item <= c;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  // Mostly short counts so timers really expire; now and then a full word.
  function automatic logic [31:0] pick_count(input int zero_weight);
    int r;
    r = $urandom_range(0, 9);
    if (r < zero_weight) return 32'd0;
    if (r < 8) return 32'($urandom_range(1, 6));
    if (r == 8) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  // Set up and run one timer for a few ticks, with queries and a wrap-up.
  task automatic run_sequence();
    logic [2:0] id;
    int         ticks;
    id = 3'($urandom_range(0, NUM_TIMERS - 1));
    issue(ACT_INIT, id, pick_count(3), pick_count(4), 1'($urandom));
    if ($urandom_range(0, 3) != 0) issue(ACT_START, id, $urandom, $urandom, 1'($urandom));
    ticks = $urandom_range(1, 6);
    repeat (ticks) begin
      issue(ACT_TICK, 3'($urandom), $urandom, $urandom, 1'($urandom));
      if ($urandom_range(0, 2) == 0)
        issue(ACT_QUERY, 3'($urandom), $urandom, $urandom, 1'($urandom));
    end
    case ($urandom_range(0, 4))
      0: issue(ACT_STOP, id, $urandom, $urandom, 1'($urandom));
      1: issue(ACT_DESTROY, id, $urandom, $urandom, 1'($urandom));
      2: issue(ACT_QUERY, id, $urandom, $urandom, 1'($urandom));
      default: ;
    endcase
  endtask

  // One free command, any action, fields at random.
  task automatic run_single();
    logic [2:0] code;
    if ($urandom_range(0, 49) == 0)
      code = ($urandom_range(0, 1) == 0) ? ACT_UNDEF_A : ACT_UNDEF_B;
    else
      code = 3'($urandom_range(0, 5));
    if (code == ACT_INIT)
      issue(code, 3'($urandom), pick_count(3), pick_count(4), 1'($urandom));
    else
      issue(code, 3'($urandom), $urandom, $urandom, 1'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: destroyed timers after reset, immediate expiry of a zero
    // count, delay then period reload, stop and restart, destroy of a
    // running timer, full-width fields and the undefined codes.
    issue(ACT_QUERY,   3'd0, '1, '1, 1'b1);
    issue(ACT_START,   3'd0, '0, '0, 1'b0);
    issue(ACT_INIT,    3'd0, 32'd0, 32'd0, 1'b1);
    issue(ACT_QUERY,   3'd0, '0, '0, 1'b0);
    issue(ACT_START,   3'd0, '0, '0, 1'b0);
    issue(ACT_TICK,    3'd0, '0, '0, 1'b0);
    issue(ACT_QUERY,   3'd0, '0, '0, 1'b0);
    issue(ACT_INIT,    3'd1, 32'd2, 32'd3, 1'b0);
    issue(ACT_START,   3'd1, '0, '0, 1'b0);
    issue(ACT_TICK,    3'd7, '1, '1, 1'b1);
    issue(ACT_TICK,    3'd0, '0, '0, 1'b0);
    issue(ACT_INIT,    3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    issue(ACT_START,   3'd7, '0, '0, 1'b0);
    issue(ACT_STOP,    3'd1, '0, '0, 1'b0);
    issue(ACT_QUERY,   3'd1, '0, '0, 1'b0);
    issue(ACT_STOP,    3'd1, '0, '0, 1'b0);
    issue(ACT_START,   3'd1, '0, '0, 1'b0);
    issue(ACT_DESTROY, 3'd1, '0, '0, 1'b0);
    issue(ACT_QUERY,   3'd1, '0, '0, 1'b0);
    issue(ACT_QUERY,   3'd7, '0, '0, 1'b0);
    issue(ACT_TICK,    3'd0, '0, '0, 1'b0);
    issue(ACT_UNDEF_A, 3'd7, '1, '1, 1'b1);
    issue(ACT_UNDEF_B, 3'd3, '1, '1, 1'b1);
    issue(ACT_DESTROY, 3'd7, '0, '0, 1'b0);
    issue(ACT_QUERY,   3'd7, '0, '0, 1'b0);

    // Random: mostly well-formed timer sequences, some loose commands.
    while (issued < ITEM_COUNT) begin
      if ($urandom_range(0, 9) < 7) run_sequence();
      else run_single();
    end

    // Drain: wait for every owed beat, then go on watching the result channel
    // to catch anything unasked for.
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (2 * NUM_TIMERS + 4) @(posedge clk);

    if (board.failures == 0 && board.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
